/* src/ffa_pkg.sv */
// Shared types and constants for the first-fit allocator core.
`default_nettype none
package ffa_pkg;

    localparam int ADDR_W = 17;
    localparam int LEN_W  = 18;

    localparam logic [LEN_W-1:0] HEAP_RESET = 18'd100000;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_ALLOC  = 3'd0;
    localparam logic [2:0] ST_FREED  = 3'd1;
    localparam logic [2:0] ST_NOFIT  = 3'd2;
    localparam logic [2:0] ST_NOADDR = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic              kind;
        logic [LEN_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] release_address;
    } in_word_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } out_word_t;

    // One table entry: a range start and its length
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } ent_t;

endpackage
`default_nettype wire

/* src/ffa_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module ffa_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 35
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/ffa_ctrl.sv */
// Request sequencer: scans and edits the free and used tables, holds the result.
`default_nettype none
module ffa_ctrl #(
    parameter int FREE_SLOTS = 64,
    parameter int USED_SLOTS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [ffa_pkg::LEN_W-1:0]     cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire ffa_pkg::in_word_t             in_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output ffa_pkg::out_word_t                 out_word,
    output logic                               f_we,
    output logic [$clog2(FREE_SLOTS)-1:0]      f_waddr,
    output ffa_pkg::ent_t                      f_wdata,
    output logic [$clog2(FREE_SLOTS)-1:0]      f_raddr,
    input  wire ffa_pkg::ent_t                 f_rdata,
    output logic                               u_we,
    output logic [$clog2(USED_SLOTS)-1:0]      u_waddr,
    output ffa_pkg::ent_t                      u_wdata,
    output logic [$clog2(USED_SLOTS)-1:0]      u_raddr,
    input  wire ffa_pkg::ent_t                 u_rdata
);

    localparam int FCNT_W = $clog2(FREE_SLOTS + 1);
    localparam int FIDX_W = $clog2(FREE_SLOTS);
    localparam int UCNT_W = $clog2(USED_SLOTS + 1);
    localparam int UIDX_W = $clog2(USED_SLOTS);
    localparam int AW     = ffa_pkg::ADDR_W;
    localparam int LW     = ffa_pkg::LEN_W;
    localparam logic [32:0] HEAP_LIMIT = 33'(1) << AW;

    typedef enum logic [16:0] {
        S_INIT   = 17'b00000000000000001,
        S_IDLE   = 17'b00000000000000010,
        S_A_RD   = 17'b00000000000000100,
        S_A_CHK  = 17'b00000000000001000,
        S_U_RD   = 17'b00000000000010000,
        S_U_CHK  = 17'b00000000000100000,
        S_F_RD   = 17'b00000000001000000,
        S_F_CHK  = 17'b00000000010000000,
        S_F_DEC  = 17'b00000000100000000,
        S_FSH_RD = 17'b00000001000000000,
        S_FSH_WR = 17'b00000010000000000,
        S_INS_RD = 17'b00000100000000000,
        S_INS_WR = 17'b00001000000000000,
        S_USH_RD = 17'b00010000000000000,
        S_USH_WR = 17'b00100000000000000,
        S_DONE   = 17'b01000000000000000,
        S_SPARE  = 17'b10000000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [LW-1:0]       heap_reg, heap_next;
    logic [FCNT_W-1:0]   fcount_reg, fcount_next;
    logic [UCNT_W-1:0]   ucount_reg, ucount_next;
    logic [FCNT_W-1:0]   fi_reg, fi_next;
    logic [UCNT_W-1:0]   ui_reg, ui_next;
    logic                op_reg, op_next;
    logic [LW-1:0]       req_reg, req_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [LW-1:0]       len_reg, len_next;
    ffa_pkg::ent_t       prev_reg, prev_next;
    ffa_pkg::ent_t       cur_reg, cur_next;
    ffa_pkg::out_word_t  res_reg, res_next;
    logic                oval_reg, oval_next;
    ffa_pkg::out_word_t  oword_reg, oword_next;

    logic [LW-1:0]       sat_heap;
    logic [AW+1:0]       free_end;
    logic [AW+1:0]       prev_end;
    logic                join_lo;
    logic                join_hi;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = oval_reg;
    assign out_word  = oword_reg;

    // Clamp the heap size to the address space
    assign sat_heap = ({15'd0, cfg_wdata} > HEAP_LIMIT) ? HEAP_LIMIT[LW-1:0] : cfg_wdata;

    // Neighbor tests for a freed range
    assign free_end = {2'b00, addr_reg} + {1'b0, len_reg};
    assign prev_end = {2'b00, prev_reg.start} + {1'b0, prev_reg.len};
    assign join_lo  = (fi_reg != '0) && (prev_end == {2'b00, addr_reg});
    assign join_hi  = (fi_reg < fcount_reg) && ({2'b00, cur_reg.start} == free_end);

    // Sequencer next state and table accesses
    always_comb
    begin
        state_next  = state_reg;
        heap_next   = heap_reg;
        fcount_next = fcount_reg;
        ucount_next = ucount_reg;
        fi_next     = fi_reg;
        ui_next     = ui_reg;
        op_next     = op_reg;
        req_next    = req_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        res_next    = res_reg;
        oval_next   = oval_reg;
        oword_next  = oword_reg;
        f_we        = 1'b0;
        f_waddr     = fi_reg[FIDX_W-1:0];
        f_wdata     = f_rdata;
        f_raddr     = fi_reg[FIDX_W-1:0];
        u_we        = 1'b0;
        u_waddr     = ui_reg[UIDX_W-1:0];
        u_wdata     = u_rdata;
        u_raddr     = ui_reg[UIDX_W-1:0];

        // Drop the output word once taken
        if (oval_reg && !out_stall)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                f_we          = 1'b1;
                f_waddr       = '0;
                f_wdata.start = '0;
                f_wdata.len   = heap_reg;
                state_next    = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_word.kind;
                    req_next  = in_word.request_bytes;
                    addr_next = in_word.release_address;
                    fi_next   = '0;
                    ui_next   = '0;
                    if (in_word.kind == ffa_pkg::KIND_ALLOC)
                    begin
                        res_next = '{ffa_pkg::ST_NOFIT, '0, '0};
                        if (in_word.request_bytes == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else if (ucount_reg >= UCNT_W'(USED_SLOTS))
                        begin
                            res_next.status = ffa_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else if (fcount_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        res_next = '{ffa_pkg::ST_NOADDR, in_word.release_address, '0};
                        state_next = (ucount_reg == '0) ? S_DONE : S_U_RD;
                    end
                end
            end
            S_A_RD:
            begin
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (f_rdata.len >= req_reg)
                begin
                    res_next    = '{ffa_pkg::ST_ALLOC, f_rdata.start, req_reg};
                    u_we        = 1'b1;
                    u_waddr     = ucount_reg[UIDX_W-1:0];
                    u_wdata     = '{f_rdata.start, req_reg};
                    ucount_next = ucount_reg + UCNT_W'(1);
                    if (f_rdata.len > req_reg)
                    begin
                        // Shrink the chunk from its low end
                        f_we          = 1'b1;
                        f_wdata.start = f_rdata.start + req_reg[AW-1:0];
                        f_wdata.len   = f_rdata.len - req_reg;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FSH_RD;
                    end
                end
                else if (fi_reg + FCNT_W'(1) < fcount_reg)
                begin
                    fi_next    = fi_reg + FCNT_W'(1);
                    state_next = S_A_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_U_RD:
            begin
                state_next = S_U_CHK;
            end
            S_U_CHK:
            begin
                if (u_rdata.start == addr_reg)
                begin
                    len_next   = u_rdata.len;
                    fi_next    = '0;
                    state_next = (fcount_reg == '0) ? S_F_DEC : S_F_RD;
                end
                else if (ui_reg + UCNT_W'(1) < ucount_reg)
                begin
                    ui_next    = ui_reg + UCNT_W'(1);
                    state_next = S_U_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_F_RD:
            begin
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (f_rdata.start > addr_reg)
                begin
                    cur_next   = f_rdata;
                    state_next = S_F_DEC;
                end
                else
                begin
                    prev_next  = f_rdata;
                    fi_next    = fi_reg + FCNT_W'(1);
                    state_next = (fi_reg + FCNT_W'(1) < fcount_reg) ? S_F_RD : S_F_DEC;
                end
            end
            S_F_DEC:
            begin
                if (!join_lo && !join_hi && fcount_reg >= FCNT_W'(FREE_SLOTS))
                begin
                    res_next   = '{ffa_pkg::ST_FULL, addr_reg, '0};
                    state_next = S_DONE;
                end
                else
                begin
                    res_next = '{ffa_pkg::ST_FREED, addr_reg, len_reg};
                    if (join_lo)
                    begin
                        // Grow the lower neighbor, also absorbing the upper one when it joins
                        f_we          = 1'b1;
                        f_waddr       = FIDX_W'(fi_reg - FCNT_W'(1));
                        f_wdata.start = prev_reg.start;
                        f_wdata.len   = join_hi ? prev_reg.len + len_reg + cur_reg.len
                                                : prev_reg.len + len_reg;
                        state_next    = join_hi ? S_FSH_RD : S_USH_RD;
                    end
                    else if (join_hi)
                    begin
                        f_we       = 1'b1;
                        f_wdata    = '{addr_reg, len_reg + cur_reg.len};
                        state_next = S_USH_RD;
                    end
                    else
                    begin
                        // Open a slot by moving entries up
                        prev_next.start = '0;
                        fi_next         = fcount_reg;
                        cur_next.start  = AW'(fi_reg);
                        state_next      = S_INS_RD;
                    end
                end
            end
            S_FSH_RD:
            begin
                // Close the gap at fi by moving entries down
                if (fi_reg + FCNT_W'(1) < fcount_reg)
                begin
                    f_raddr    = FIDX_W'(fi_reg + FCNT_W'(1));
                    state_next = S_FSH_WR;
                end
                else
                begin
                    fcount_next = fcount_reg - FCNT_W'(1);
                    state_next  = (op_reg == ffa_pkg::KIND_ALLOC) ? S_DONE : S_USH_RD;
                end
            end
            S_FSH_WR:
            begin
                f_we       = 1'b1;
                fi_next    = fi_reg + FCNT_W'(1);
                state_next = S_FSH_RD;
            end
            S_INS_RD:
            begin
                // cur_reg.start holds the insertion slot here
                if (fi_reg > FCNT_W'(cur_reg.start))
                begin
                    f_raddr    = FIDX_W'(fi_reg - FCNT_W'(1));
                    state_next = S_INS_WR;
                end
                else
                begin
                    f_we        = 1'b1;
                    f_wdata     = '{addr_reg, len_reg};
                    fcount_next = fcount_reg + FCNT_W'(1);
                    state_next  = S_USH_RD;
                end
            end
            S_INS_WR:
            begin
                f_we       = 1'b1;
                fi_next    = fi_reg - FCNT_W'(1);
                state_next = S_INS_RD;
            end
            S_USH_RD:
            begin
                // Remove the used entry at ui by moving entries down
                if (ui_reg + UCNT_W'(1) < ucount_reg)
                begin
                    u_raddr    = UIDX_W'(ui_reg + UCNT_W'(1));
                    state_next = S_USH_WR;
                end
                else
                begin
                    ucount_next = ucount_reg - UCNT_W'(1);
                    state_next  = S_DONE;
                end
            end
            S_USH_WR:
            begin
                u_we       = 1'b1;
                ui_next    = ui_reg + UCNT_W'(1);
                state_next = S_USH_RD;
            end
            S_DONE:
            begin
                // Hand the word over once the output register is free
                if (!oval_reg || !out_stall)
                begin
                    oval_next  = 1'b1;
                    oword_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Reinitialize the heap on a configuration write
        if (cfg_we)
        begin
            heap_next   = sat_heap;
            fcount_next = (sat_heap != '0) ? FCNT_W'(1) : '0;
            ucount_next = '0;
            state_next  = S_INIT;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            heap_reg   <= ffa_pkg::HEAP_RESET;
            fcount_reg <= FCNT_W'(1);
            ucount_reg <= '0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            heap_reg   <= heap_next;
            fcount_reg <= fcount_next;
            ucount_reg <= ucount_next;
            oval_reg   <= oval_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        fi_reg    <= fi_next;
        ui_reg    <= ui_next;
        op_reg    <= op_next;
        req_reg   <= req_next;
        addr_reg  <= addr_next;
        len_reg   <= len_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        res_reg   <= res_next;
        oword_reg <= oword_next;
    end

endmodule
`default_nettype wire

/* src/first_fit_allocator_coalescing_core.sv */
// First-fit allocator core: sequencer plus free and used table memories.
//
// Usage: requests enter on in_word (in_valid / in_stall), one result word
// leaves on out_word (out_valid / out_stall). An allocate request scans the
// free table for the first chunk large enough; a free request scans the used
// table for the start address, then the free table for its neighbors.
// Each table entry scanned is first read and then examined, and each entry
// moved when a table is compacted or opened is first read and then written;
// each table is scanned and moved through at most once per request.
// One request is worked on at a time; in_stall is low only when idle.
// A finished word waits in an output register, so the next request is taken
// while a stalled word is still held. After reset the heap is 100000 bytes;
// in the init state after reset, and in the cycle after a cfg_we write, the
// first free entry is written and requests are stalled. cfg_we sets the heap
// size and empties the used table.
`default_nettype none
module first_fit_allocator_coalescing_core #(
    parameter int FREE_SLOTS = 64,
    parameter int USED_SLOTS = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [ffa_pkg::LEN_W-1:0] cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire ffa_pkg::in_word_t         in_word,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output ffa_pkg::out_word_t             out_word
);

    localparam int FIDX_W = $clog2(FREE_SLOTS);
    localparam int UIDX_W = $clog2(USED_SLOTS);
    localparam int ENT_W  = $bits(ffa_pkg::ent_t);

    logic              f_we;
    logic [FIDX_W-1:0] f_waddr;
    logic [FIDX_W-1:0] f_raddr;
    ffa_pkg::ent_t     f_wdata;
    ffa_pkg::ent_t     f_rdata;
    logic              u_we;
    logic [UIDX_W-1:0] u_waddr;
    logic [UIDX_W-1:0] u_raddr;
    ffa_pkg::ent_t     u_wdata;
    ffa_pkg::ent_t     u_rdata;

    // Sequencer
    ffa_ctrl #(
        .FREE_SLOTS (FREE_SLOTS),
        .USED_SLOTS (USED_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .f_we      (f_we),
        .f_waddr   (f_waddr),
        .f_wdata   (f_wdata),
        .f_raddr   (f_raddr),
        .f_rdata   (f_rdata),
        .u_we      (u_we),
        .u_waddr   (u_waddr),
        .u_wdata   (u_wdata),
        .u_raddr   (u_raddr),
        .u_rdata   (u_rdata)
    );

    // Free chunk table, address ordered
    ffa_ram #(
        .DEPTH (FREE_SLOTS),
        .WIDTH (ENT_W)
    ) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // Allocated range table, allocation ordered
    ffa_ram #(
        .DEPTH (USED_SLOTS),
        .WIDTH (ENT_W)
    ) u_used_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

endmodule
`default_nettype wire

/* sim/first_fit_allocator_coalescing_core_tb.sv */
// Self-checking testbench for the first-fit allocator core with coalescing.
`timescale 1ns / 100ps
`default_nettype none
module first_fit_allocator_coalescing_core_tb;

    localparam int FREE_DEPTH = 64;
    localparam int USED_DEPTH = 64;
    localparam int HEAP_MAX   = 131072;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [ffa_pkg::LEN_W-1:0] cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    ffa_pkg::in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    ffa_pkg::out_word_t out_word;

    // Shadow copy of the allocator tables
    int unsigned free_base [FREE_DEPTH];
    int unsigned free_size [FREE_DEPTH];
    int unsigned free_num;
    int unsigned used_base [USED_DEPTH];
    int unsigned used_size [USED_DEPTH];
    int unsigned used_num;

    ffa_pkg::out_word_t pending_results[$];
    int  error_count = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  stall_busy = 1'b0;

    first_fit_allocator_coalescing_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always #4 clk = ~clk;

    // Reset the shadow heap to a single chunk, or to none for zero bytes
    function automatic void heap_init(int unsigned bytes);
        if (bytes > HEAP_MAX)
        begin
            bytes = HEAP_MAX;
        end
        free_base[0] = 0;
        free_size[0] = bytes;
        free_num = (bytes != 0) ? 1 : 0;
        used_num = 0;
    endfunction

    // Apply one request to the shadow tables and return its result word
    function automatic ffa_pkg::out_word_t heap_apply(ffa_pkg::in_word_t w);
        ffa_pkg::out_word_t r;
        int unsigned i, j, u, len, stop;
        bit lo, hi;
        r = '0;
        if (w.kind == ffa_pkg::KIND_ALLOC)
        begin
            r.status = ffa_pkg::ST_NOFIT;
            if (w.request_bytes == 0)
            begin
                return r;
            end
            if (used_num >= USED_DEPTH)
            begin
                r.status = ffa_pkg::ST_FULL;
                return r;
            end
            for (i = 0; i < free_num; i++)
            begin
                if (free_size[i] >= w.request_bytes)
                begin
                    break;
                end
            end
            if (i >= free_num)
            begin
                return r;
            end
            r.address = free_base[i][ffa_pkg::ADDR_W-1:0];
            if (free_size[i] > w.request_bytes)
            begin
                free_base[i] += w.request_bytes;
                free_size[i] -= w.request_bytes;
            end
            else
            begin
                for (j = i; j + 1 < free_num; j++)
                begin
                    free_base[j] = free_base[j + 1];
                    free_size[j] = free_size[j + 1];
                end
                free_num--;
            end
            used_base[used_num] = r.address;
            used_size[used_num] = w.request_bytes;
            used_num++;
            r.status = ffa_pkg::ST_ALLOC;
            r.length = w.request_bytes;
            return r;
        end
        r.address = w.release_address;
        for (u = 0; u < used_num; u++)
        begin
            if (used_base[u] == w.release_address)
            begin
                break;
            end
        end
        if (u >= used_num)
        begin
            r.status = ffa_pkg::ST_NOADDR;
            return r;
        end
        len = used_size[u];
        stop = w.release_address + len;
        for (i = 0; i < free_num; i++)
        begin
            if (free_base[i] > w.release_address)
            begin
                break;
            end
        end
        lo = (i > 0) && (free_base[i - 1] + free_size[i - 1] == w.release_address);
        hi = (i < free_num) && (free_base[i] == stop);
        if (!lo && !hi && free_num >= FREE_DEPTH)
        begin
            r.status = ffa_pkg::ST_FULL;
            return r;
        end
        if (lo && hi)
        begin
            free_size[i - 1] += len + free_size[i];
            for (j = i; j + 1 < free_num; j++)
            begin
                free_base[j] = free_base[j + 1];
                free_size[j] = free_size[j + 1];
            end
            free_num--;
        end
        else if (lo)
        begin
            free_size[i - 1] += len;
        end
        else if (hi)
        begin
            free_base[i] = w.release_address;
            free_size[i] += len;
        end
        else
        begin
            for (j = free_num; j > i; j--)
            begin
                free_base[j] = free_base[j - 1];
                free_size[j] = free_size[j - 1];
            end
            free_base[i] = w.release_address;
            free_size[i] = len;
            free_num++;
        end
        for (j = u; j + 1 < used_num; j++)
        begin
            used_base[j] = used_base[j + 1];
            used_size[j] = used_size[j + 1];
        end
        used_num--;
        r.status = ffa_pkg::ST_FREED;
        r.length = len[ffa_pkg::LEN_W-1:0];
        return r;
    endfunction

    // Random gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(10, 60);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    // Present one word and hold it until accepted; predict on acceptance
    task automatic send_word(ffa_pkg::in_word_t w, bit busy_gaps);
        int g;
        g = busy_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_results.push_back(heap_apply(w));
    endtask

    // Wait until all results are back, plus a settle margin
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_heap(int unsigned bytes);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= bytes[ffa_pkg::LEN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        heap_init(bytes & 32'h3FFFF);
        @(posedge clk);
    endtask

    function automatic ffa_pkg::in_word_t mk(logic k, int unsigned req, int unsigned addr);
        ffa_pkg::in_word_t w;
        w.kind = k;
        w.request_bytes = req[ffa_pkg::LEN_W-1:0];
        w.release_address = addr[ffa_pkg::ADDR_W-1:0];
        return w;
    endfunction

    // Receiver: random stall, check against oldest prediction
    always @(posedge clk)
    begin
        ffa_pkg::out_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word status=%0d", out_word.status);
                error_count++;
            end
            else
            begin
                exp_w = pending_results.pop_front();
                if (out_word.status !== exp_w.status)
                begin
                    $error("status: expected %0d, got %0d", exp_w.status, out_word.status);
                    error_count++;
                end
                if (out_word.address !== exp_w.address)
                begin
                    $error("address: expected %0d, got %0d", exp_w.address, out_word.address);
                    error_count++;
                end
                if (out_word.length !== exp_w.length)
                begin
                    $error("length: expected %0d, got %0d", exp_w.length, out_word.length);
                    error_count++;
                end
            end
        end
        // Hold the stall for a random run, mostly short, now and then long
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_busy && $urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= gap_len();
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("first_fit_allocator_coalescing_core: mismatch");
            $finish;
        end
    end

    // Directed table: kind, size, address, typed expectation where obvious
    typedef struct {
        logic        k;
        int unsigned req;
        int unsigned addr;
        bit          typed;
        logic [2:0]  st;
        int unsigned e_addr;
        int unsigned e_len;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{ffa_pkg::KIND_ALLOC, 0,      0,      1, ffa_pkg::ST_NOFIT,  0,      0},
        '{ffa_pkg::KIND_ALLOC, 100001, 0,      1, ffa_pkg::ST_NOFIT,  0,      0},
        '{ffa_pkg::KIND_FREE,  0,      0,      1, ffa_pkg::ST_NOADDR, 0,      0},
        '{ffa_pkg::KIND_FREE,  0,      131071, 1, ffa_pkg::ST_NOADDR, 131071, 0},
        '{ffa_pkg::KIND_ALLOC, 1,      0,      1, ffa_pkg::ST_ALLOC,  0,      1},
        '{ffa_pkg::KIND_ALLOC, 10,     0,      1, ffa_pkg::ST_ALLOC,  1,      10},
        '{ffa_pkg::KIND_ALLOC, 20,     0,      1, ffa_pkg::ST_ALLOC,  11,     20},
        '{ffa_pkg::KIND_ALLOC, 30,     0,      1, ffa_pkg::ST_ALLOC,  31,     30},
        '{ffa_pkg::KIND_FREE,  0,      11,     1, ffa_pkg::ST_FREED,  11,     20},
        '{ffa_pkg::KIND_FREE,  0,      11,     1, ffa_pkg::ST_NOADDR, 11,     0},
        '{ffa_pkg::KIND_FREE,  0,      0,      0, 0, 0, 0},
        '{ffa_pkg::KIND_FREE,  0,      31,     0, 0, 0, 0},
        '{ffa_pkg::KIND_ALLOC, 5,      0,      0, 0, 0, 0},
        '{ffa_pkg::KIND_FREE,  0,      1,      0, 0, 0, 0},
        '{ffa_pkg::KIND_ALLOC, 99999,  0,      0, 0, 0, 0},
        '{ffa_pkg::KIND_FREE,  0,      0,      0, 0, 0, 0},
        '{ffa_pkg::KIND_ALLOC, 262143, 0,      1, ffa_pkg::ST_NOFIT,  0,      0}
    };

    // Fill the used table, then fragment the free table and coalesce it again
    task automatic stress_tables();
        int k;
        write_heap(200);
        for (k = 0; k < 65; k++)
        begin
            send_word(mk(ffa_pkg::KIND_ALLOC, 1, 0), 1'b1);
        end
        for (k = 0; k < 64; k += 2)
        begin
            send_word(mk(ffa_pkg::KIND_FREE, 0, k), 1'b1);
        end
        send_word(mk(ffa_pkg::KIND_ALLOC, 200, 0), 1'b1);
        for (k = 1; k < 64; k += 2)
        begin
            send_word(mk(ffa_pkg::KIND_FREE, 0, k), 1'b1);
        end
        // Coalesce a long run of adjacent two-byte ranges
        write_heap(300);
        for (k = 0; k < 64; k++)
        begin
            send_word(mk(ffa_pkg::KIND_ALLOC, 2, 0), 1'b1);
        end
        for (k = 0; k < 64; k++)
        begin
            send_word(mk(ffa_pkg::KIND_FREE, 0, 2 * k), 1'b1);
        end
    endtask

    task automatic random_phase(int unsigned heap, int n, int unsigned max_req);
        int k, pick;
        write_heap(heap);
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_word(mk(ffa_pkg::KIND_ALLOC, $urandom_range(1, max_req), $urandom), 1'b1);
            end
            else if (pick < 90 && used_num != 0)
            begin
                send_word(mk(ffa_pkg::KIND_FREE, $urandom,
                    used_base[$urandom_range(0, used_num - 1)]), 1'b1);
            end
            else if (pick < 95)
            begin
                send_word(mk(1'($urandom_range(0, 1)), $urandom, $urandom), 1'b1);
            end
            else
            begin
                send_word(mk(ffa_pkg::KIND_ALLOC, $urandom_range(1, 262143), 0), 1'b1);
            end
        end
    endtask

    initial
    begin
        ffa_pkg::out_word_t e;
        heap_init(ffa_pkg::HEAP_RESET);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed rows after reset
        foreach (dir_rows[k])
        begin
            send_word(mk(dir_rows[k].k, dir_rows[k].req, dir_rows[k].addr), 1'b0);
            if (dir_rows[k].typed)
            begin
                e.status  = dir_rows[k].st;
                e.address = dir_rows[k].e_addr[ffa_pkg::ADDR_W-1:0];
                e.length  = dir_rows[k].e_len[ffa_pkg::LEN_W-1:0];
                if (pending_results[$] !== e)
                begin
                    $error("table row %0d: predictor disagrees with typed result", k);
                    error_count++;
                end
            end
        end
        // Heap size extremes
        write_heap(0);
        send_word(mk(ffa_pkg::KIND_ALLOC, 1, 0), 1'b0);
        write_heap(1);
        send_word(mk(ffa_pkg::KIND_ALLOC, 1, 0), 1'b0);
        send_word(mk(ffa_pkg::KIND_FREE, 0, 0), 1'b0);
        write_heap(262143);
        send_word(mk(ffa_pkg::KIND_ALLOC, 131072, 0), 1'b0);
        send_word(mk(ffa_pkg::KIND_FREE, 0, 0), 1'b0);
        write_heap(131072);
        send_word(mk(ffa_pkg::KIND_ALLOC, 131072, 0), 1'b0);

        stall_busy = 1'b1;
        stress_tables();
        random_phase(1000, 60, 120);
        random_phase(131072, 60, 20000);
        random_phase(64, 50, 8);
        random_phase(100000, 50, 262143);

        drain();
        if (error_count == 0)
        begin
            $display("first_fit_allocator_coalescing_core: match");
        end
        else
        begin
            $display("first_fit_allocator_coalescing_core: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
src/ffa_pkg.sv
src/ffa_ram.sv
src/ffa_ctrl.sv
src/first_fit_allocator_coalescing_core.sv
sim/first_fit_allocator_coalescing_core_tb.sv
